>>> hw/rtl/efdb_pkg.sv
// Shared types and constants for the exact float difference bit unit.
// Used by exact_float_difference_bits_unit and its checker; no dependencies.
package efdb_pkg;

  localparam int unsigned MantBits = 23;
  localparam int unsigned FracBits = MantBits + 1;
  localparam logic [31:0] PatOne   = 32'h3F80_0000;
  localparam logic [31:0] PatHalf  = 32'h3F00_0000;
  localparam logic [31:0] PatNegZero = 32'h8000_0000;
  localparam logic [7:0]  ExpMax   = 8'hFF;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FLAGS = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  // Operands ordered and unpacked
  typedef struct packed {
    err_e        err;
    logic        comp;
    logic        one;
    logic        half;
    logic [23:0] fx;
    logic [23:0] fy;
    logic [7:0]  exa;
    logic [6:0]  diff;
    logic [8:0]  idx;
  } s1_t;

  // Run-length descriptor before the bit lookup
  typedef struct packed {
    err_e        err;
    logic [7:0]  n1;
    logic        b1;
    logic [4:0]  nhi;
    logic [24:0] ghi;
    logic [6:0]  n2;
    logic        b2;
    logic [4:0]  nlo;
    logic [23:0] glo;
    logic [8:0]  idx;
  } s2_t;

  typedef struct packed {
    err_e        err;
    logic [7:0]  n1;
    logic        b1;
    logic [4:0]  nhi;
    logic [24:0] ghi;
    logic [6:0]  n2;
    logic        b2;
    logic [4:0]  nlo;
    logic [23:0] glo;
    logic        sel;
  } res_t;

endpackage

>>> hw/rtl/exact_float_difference_bits_unit.sv
// Throughput one item per cycle while the output does not stall. An accepted item
// passes through the stage 1, stage 2 and result registers before it is offered.
// Three register stages: operand ordering and checks, alignment shift and
// subtraction, bit lookup. Each stage holds its item on a stall and fills
// bubbles, so the input keeps accepting while a result waits at the output
// until all three stages hold items.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
// Depends on efdb_pkg.
module exact_float_difference_bits_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // value_a [31:0], value_b [63:32], bit_index [72:64], zero [79:73]
  input  logic [efdb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // dir_a [0], dir_b [1]
  input  logic [efdb_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // lead_len [7:0], lead_bit [8], high_len [13:9], high_bits [38:14],
  // mid_len [45:39], mid_bit [46], low_len [51:47], low_bits [75:52],
  // selected_bit [76], zero [79:77]
  output logic [efdb_pkg::OutDataW-1:0] m_axis_tdata_o,
  // error [1:0]
  output logic [efdb_pkg::OutUserW-1:0] m_axis_tuser_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  efdb_pkg::s1_t  s1_d, s1_q;
  efdb_pkg::s2_t  s2_d, s2_q;
  efdb_pkg::res_t res_d, res_q;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  // ---------------- stage 1: order operands, check range ----------------
  logic        dir_a, dir_b, comp, swap;
  logic [31:0] va, vb, xr, yr, xo, yo, x, y;
  logic        bad_flags, bad_fmt, bad_sub, bad_comp;
  logic [7:0]  ex, ey, exa, eya;
  logic [8:0]  diff_w;

  always_comb begin
    dir_a = s_axis_tuser_i[0];
    dir_b = s_axis_tuser_i[1];
    va    = s_axis_tdata_i[31:0];
    vb    = s_axis_tdata_i[63:32];
    bad_flags = !dir_a && dir_b;
    comp  = dir_a ^ dir_b;
    swap  = !comp && dir_a;
    xr    = swap ? vb : va;
    yr    = swap ? va : vb;
    // take negative zero as +0
    if (xr == efdb_pkg::PatNegZero) xr = '0;
    if (yr == efdb_pkg::PatNegZero) yr = '0;
    bad_fmt = xr[31] || yr[31] ||
              (xr[30:23] == efdb_pkg::ExpMax) || (yr[30:23] == efdb_pkg::ExpMax);
    bad_sub = (yr > xr) || (xr > efdb_pkg::PatOne) ||
              ((xr == efdb_pkg::PatOne) && (yr == '0));
    xo = (xr < yr) ? yr : xr;
    yo = (xr < yr) ? xr : yr;
    bad_comp = (xo > efdb_pkg::PatHalf) ||
               ((xo == efdb_pkg::PatHalf) && (yo == efdb_pkg::PatHalf)) ||
               ((xo == '0) && (yo == '0));
    x  = comp ? xo : xr;
    y  = comp ? yo : yr;
    ex = x[30:23];
    ey = y[30:23];
    // subnormals share the exponent of the smallest normal
    exa = (ex == '0) ? 8'd1 : ex;
    eya = (ey == '0) ? 8'd1 : ey;
    diff_w = {1'b0, exa} - {1'b0, eya};

    if (bad_flags) begin
      s1_d.err = efdb_pkg::ERR_FLAGS;
    end else if (bad_fmt || (comp ? bad_comp : bad_sub)) begin
      s1_d.err = efdb_pkg::ERR_RANGE;
    end else begin
      s1_d.err = efdb_pkg::ERR_OK;
    end
    s1_d.comp = comp;
    s1_d.one  = (x == efdb_pkg::PatOne);
    s1_d.half = (x == efdb_pkg::PatHalf);
    s1_d.fx   = {(ex != '0), x[22:0]};
    s1_d.fy   = {(ey != '0), y[22:0]};
    s1_d.exa  = exa;
    s1_d.diff = diff_w[6:0];
    s1_d.idx  = s_axis_tdata_i[72:64];
  end

  // ---------------- stage 2: align and subtract ----------------
  logic [23:0] fhi, lo_mask, flo;
  logic [24:0] glo_w, top_w;
  logic [8:0]  n1_w;
  logic [4:0]  nlo, nhi;
  logic        b2;

  always_comb begin
    fhi     = s1_q.fy >> s1_q.diff;
    nlo     = (s1_q.diff < 7'(efdb_pkg::FracBits)) ? s1_q.diff[4:0]
                                                   : 5'(efdb_pkg::FracBits);
    lo_mask = 24'((25'd1 << nlo) - 25'd1);
    flo     = s1_q.fy & lo_mask;
    b2      = |flo;
    glo_w   = (25'(b2) << nlo) - {1'b0, flo};
    if (s1_q.comp) begin
      n1_w  = 9'd125 - {1'b0, s1_q.exa} + 9'(s1_q.half);
      nhi   = 5'(efdb_pkg::FracBits + 1) - 5'(s1_q.half);
      top_w = 25'd1 << nhi;
    end else begin
      n1_w  = 9'd126 - {1'b0, s1_q.exa} + 9'(s1_q.one);
      nhi   = 5'(efdb_pkg::FracBits) - 5'(s1_q.one);
      top_w = {1'b0, s1_q.fx};
    end
    s2_d.err = s1_q.err;
    s2_d.n1  = n1_w[7:0];
    s2_d.b1  = s1_q.comp;
    s2_d.nhi = nhi;
    s2_d.ghi = s1_q.comp ? (top_w - {1'b0, s1_q.fx} - {1'b0, fhi} - 25'(b2))
                         : (top_w - {1'b0, fhi} - 25'(b2));
    s2_d.n2  = (s1_q.diff > 7'(efdb_pkg::FracBits)) ?
               (s1_q.diff - 7'(efdb_pkg::FracBits)) : 7'd0;
    s2_d.b2  = b2;
    s2_d.nlo = nlo;
    s2_d.glo = glo_w[23:0];
    s2_d.idx = s1_q.idx;
  end

  // ---------------- stage 3: pick the indexed bit ----------------
  logic signed [10:0] e1, e2, e3, e4, li;
  logic [10:0]        off_hi, off_lo;
  logic               sel;

  always_comb begin
    e1 = {{3{s2_q.n1[7]}}, s2_q.n1};
    e2 = e1 + $signed({6'd0, s2_q.nhi});
    e3 = e2 + $signed({4'd0, s2_q.n2});
    e4 = e3 + $signed({6'd0, s2_q.nlo});
    li = $signed({2'd0, s2_q.idx});
    off_hi = 11'(e2 - li);
    off_lo = 11'(e4 - li);
    priority if (li <= e1) begin
      sel = s2_q.b1;
    end else if (li <= e2) begin
      sel = s2_q.ghi[off_hi[4:0]];
    end else if (li <= e3) begin
      sel = s2_q.b2;
    end else if (li <= e4) begin
      sel = s2_q.glo[off_lo[4:0]];
    end else begin
      sel = 1'b0;
    end

    // any error zeroes the whole descriptor
    if (s2_q.err != efdb_pkg::ERR_OK) begin
      res_d     = '0;
      res_d.err = s2_q.err;
    end else begin
      res_d.err = s2_q.err;
      res_d.n1  = s2_q.n1;
      res_d.b1  = s2_q.b1;
      res_d.nhi = s2_q.nhi;
      res_d.ghi = s2_q.ghi;
      res_d.n2  = s2_q.n2;
      res_d.b2  = s2_q.b2;
      res_d.nlo = s2_q.nlo;
      res_d.glo = s2_q.glo;
      res_d.sel = sel;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // hold payload on a stall, advance only behind a valid item
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid_i) s1_q  <= s1_d;
    if (rdy2 && v1_q)            s2_q  <= s2_d;
    if (rdy3 && v2_q)            res_q <= res_d;
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tuser_o  = res_q.err;
  assign m_axis_tdata_o  = {3'd0, res_q.sel, res_q.glo, res_q.nlo, res_q.b2, res_q.n2,
                            res_q.ghi, res_q.nhi, res_q.b1, res_q.n1};

endmodule

>>> hw/rtl/efdb_checker.sv
// Port-level checks for exact_float_difference_bits_unit, bound to the top level.
// Depends on efdb_pkg.
module efdb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [efdb_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [efdb_pkg::OutUserW-1:0] m_axis_tuser_o
);

  // a flagged item carries an all-zero descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != efdb_pkg::ERR_OK)) |-> (m_axis_tdata_o == '0))
    else $error("flagged item with non-zero descriptor");

  // no borrow means the low block is empty of ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == efdb_pkg::ERR_OK) && !m_axis_tdata_o[46])
      |-> (m_axis_tdata_o[75:52] == '0))
    else $error("low block set without borrow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output item dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("output item changed under stall");

endmodule

bind exact_float_difference_bits_unit efdb_checker u_efdb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for exact_float_difference_bits_unit: predicts each run-length descriptor
// and compares it field by field with the result stream. Depends on efdb_pkg.
module testbench;

  localparam logic [1:0] OP_SUB      = 2'b00; // x - y, x = value_a
  localparam logic [1:0] OP_COMP     = 2'b01; // 1 - (x + y)
  localparam logic [1:0] OP_BAD      = 2'b10; // dir_a = 0, dir_b = 1
  localparam logic [1:0] OP_SUB_SWAP = 2'b11; // x - y, x = value_b
  localparam int ExpBias    = 127;
  localparam int Frac       = efdb_pkg::FracBits;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [79:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_tready = 1'b0;
  logic [79:0] m_data;
  logic [1:0]  m_user;

  efdb_pkg::res_t expected_descr[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  exact_float_difference_bits_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #5 clk_i = ~clk_i;

  function automatic efdb_pkg::res_t predict_descriptor(input logic [1:0] ops,
                                                        input logic [31:0] va,
                                                        input logic [31:0] vb,
                                                        input logic [8:0] idx);
    efdb_pkg::res_t r;
    logic [31:0] x, y, t, fx, fy, fhi, flo, ghi, glo;
    int          ehx, ehy, diff, n1, nhi, nlo, n2, l;
    logic        comp, bad, b1, b2, sel;
    r = '0;
    if (ops == OP_BAD) begin
      r.err = efdb_pkg::ERR_FLAGS;
      return r;
    end
    comp = ops[0] ^ ops[1];
    if (!comp && ops[0]) begin
      x = vb;
      y = va;
    end else begin
      x = va;
      y = vb;
    end
    if (x == efdb_pkg::PatNegZero) x = '0;
    if (y == efdb_pkg::PatNegZero) y = '0;
    bad = x[31] || y[31] || (x[30:23] == efdb_pkg::ExpMax) ||
          (y[30:23] == efdb_pkg::ExpMax);
    if (!bad) begin
      if (!comp) begin
        bad = (y > x) || (x > efdb_pkg::PatOne) || (x == efdb_pkg::PatOne && y == '0);
      end else begin
        // larger operand first
        if (x < y) begin
          t = x;
          x = y;
          y = t;
        end
        bad = (x > efdb_pkg::PatHalf) ||
              (x == efdb_pkg::PatHalf && y == efdb_pkg::PatHalf) ||
              (x == '0 && y == '0);
      end
    end
    if (bad) begin
      r.err = efdb_pkg::ERR_RANGE;
      return r;
    end
    ehx  = int'(x[30:23]) - ExpBias + ((x[30:23] == 8'd0) ? 1 : 0);
    ehy  = int'(y[30:23]) - ExpBias + ((y[30:23] == 8'd0) ? 1 : 0);
    fx   = {8'd0, x[30:23] != 8'd0, x[22:0]};
    fy   = {8'd0, y[30:23] != 8'd0, y[22:0]};
    diff = ehx - ehy;
    fhi  = fy >> ((diff < 31) ? diff : 31);
    nlo  = (diff < Frac) ? diff : Frac;
    flo  = fy & ((32'd1 << nlo) - 32'd1);
    n2   = (diff > Frac) ? diff - Frac : 0;
    b2   = (flo != '0);
    glo  = ({31'd0, b2} << nlo) - flo;
    if (!comp) begin
      n1  = -ehx - 1 + ((x == efdb_pkg::PatOne) ? 1 : 0);
      nhi = Frac - ((x == efdb_pkg::PatOne) ? 1 : 0);
      b1  = 1'b0;
      ghi = fx - fhi - {31'd0, b2};
    end else begin
      n1  = -ehx - 2 + ((x == efdb_pkg::PatHalf) ? 1 : 0);
      nhi = Frac + 1 - ((x == efdb_pkg::PatHalf) ? 1 : 0);
      b1  = 1'b1;
      ghi = (32'd1 << nhi) - fx - fhi - {31'd0, b2};
    end
    l = int'(idx);
    if (l <= n1) sel = b1;
    else if (l <= n1 + nhi) sel = ghi[n1 + nhi - l];
    else if (l <= n1 + nhi + n2) sel = b2;
    else if (l <= n1 + nhi + n2 + nlo) sel = glo[n1 + nhi + n2 + nlo - l];
    else sel = 1'b0;
    r.err = efdb_pkg::ERR_OK;
    r.n1  = n1[7:0];
    r.b1  = b1;
    r.nhi = nhi[4:0];
    r.ghi = ghi[24:0];
    r.n2  = n2[6:0];
    r.b2  = b2;
    r.nlo = nlo[4:0];
    r.glo = glo[23:0];
    r.sel = sel;
    return r;
  endfunction

  // Non-negative pattern no larger than top, biased towards close exponents
  function automatic logic [31:0] rand_pattern_upto(input logic [31:0] top);
    logic [7:0]  e;
    logic [22:0] m;
    int          span;
    case ($urandom_range(7))
      0: return top;
      1: return '0;
      2: e = 8'd0;
      3, 4: begin
        span = (top[30:23] < 8'd30) ? int'(top[30:23]) : 30;
        e = top[30:23] - 8'($urandom_range(span));
      end
      default: e = 8'($urandom_range(top[30:23]));
    endcase
    m = 23'($urandom);
    if (e == top[30:23] && m > top[22:0]) m = 23'($urandom_range(top[22:0]));
    return {1'b0, e, m};
  endfunction

  task automatic send_query(input logic [1:0] ops, input logic [31:0] va,
                            input logic [31:0] vb, input logic [8:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = ops;
    s_data  = {7'd0, idx, vb, va};
    do @(posedge clk_i); while (!s_ready);
    expected_descr.push_back(predict_descriptor(ops, va, vb, idx));
    @(negedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_query(OP_BAD,      efdb_pkg::PatHalf, 32'h3E80_0000, 9'd5);
    send_query(OP_SUB,      32'h3F40_0000, 32'h3E80_0000, 9'd1);
    send_query(OP_SUB_SWAP, 32'h3E80_0000, 32'h3F40_0000, 9'd2);
    send_query(OP_COMP,     32'h3E80_0000, 32'h3E00_0000, 9'd3);
    send_query(OP_COMP,     32'h3D80_0000, 32'h3EC0_0000, 9'd4);
    send_query(OP_SUB,      efdb_pkg::PatNegZero, 32'h0000_0000, 9'd0);
    send_query(OP_SUB,      efdb_pkg::PatHalf, efdb_pkg::PatNegZero, 9'd7);
    send_query(OP_SUB,      32'hBF00_0000, 32'h0000_0000, 9'd1);
    send_query(OP_SUB,      32'h7FC0_0000, 32'h0000_0000, 9'd1);
    send_query(OP_COMP,     32'h7F80_0000, 32'h0000_0000, 9'd1);
    send_query(OP_SUB,      32'h3E80_0000, efdb_pkg::PatHalf, 9'd1);
    send_query(OP_SUB,      32'h3F80_0001, 32'h0000_0000, 9'd1);
    send_query(OP_SUB,      efdb_pkg::PatOne, 32'h0000_0000, 9'd1);
    send_query(OP_SUB,      efdb_pkg::PatOne, 32'h0000_0001, 9'd150);
    send_query(OP_SUB,      32'h3F12_3456, 32'h3F12_3456, 9'd9);
    send_query(OP_COMP,     32'h3F00_0001, 32'h0000_0000, 9'd2);
    send_query(OP_COMP,     efdb_pkg::PatHalf, efdb_pkg::PatHalf, 9'd2);
    send_query(OP_COMP,     32'h0000_0000, efdb_pkg::PatNegZero, 9'd2);
    send_query(OP_COMP,     efdb_pkg::PatHalf, 32'h0000_0001, 9'd511);
    send_query(OP_SUB,      32'h0000_0003, 32'h0000_0001, 9'd200);
    send_query(OP_SUB,      32'h3F7F_FFFF, 32'h3380_0000, 9'd0);
    send_query(OP_SUB,      32'h3F7F_FFFF, 32'h0040_0000, 9'd511);
    send_query(OP_COMP,     32'h3E7F_FFFF, 32'h3E7F_FFFF, 9'd30);
    send_query(OP_SUB,      efdb_pkg::PatHalf, 32'h3E00_0000, 9'd26);
    send_query(OP_COMP,     32'h0000_0001, 32'h0000_0000, 9'd130);
  endtask

  task automatic test_random_queries(input int count, input int idle_pct, input int stall_pct);
    logic [31:0] x, y, t;
    logic [1:0]  ops;
    logic [8:0]  idx;
    int          kind;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      kind = $urandom_range(99);
      idx  = ($urandom_range(9) < 7) ? 9'($urandom_range(160)) : 9'($urandom_range(511));
      if (kind < 15) begin
        // noise over the whole input space
        ops = 2'($urandom_range(3));
        x   = $urandom;
        y   = $urandom;
      end else if (kind < 55) begin
        x   = rand_pattern_upto(efdb_pkg::PatOne);
        y   = rand_pattern_upto(x);
        ops = $urandom_range(1) ? OP_SUB : OP_SUB_SWAP;
        if (ops == OP_SUB_SWAP) begin
          t = x;
          x = y;
          y = t;
        end
      end else begin
        x   = rand_pattern_upto(efdb_pkg::PatHalf);
        y   = rand_pattern_upto(x);
        ops = OP_COMP;
        if ($urandom_range(1)) begin
          t = x;
          x = y;
          y = t;
        end
      end
      if (kind >= 15 && $urandom_range(19) == 0) begin
        case ($urandom_range(2))
          0: x = efdb_pkg::PatNegZero;
          1: y[31] = 1'b1;
          default: x[30:23] = efdb_pkg::ExpMax;
        endcase
      end
      send_query(ops, x, y, idx);
    end
  endtask

  // Hold the output off long enough for the pipeline to fill and stall its input
  task automatic test_output_hold();
    // drop the last item so it is not taken a second time
    s_valid = 1'b0;
    @(posedge clk_i);
    hold_left = 400;
    @(negedge clk_i);
    test_random_queries(60, 0, 0);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_tready  = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    efdb_pkg::res_t want;
    if (rst_ni && m_valid && m_tready) begin
      if (expected_descr.size() == 0) begin
        $error("result item with no query outstanding");
        mismatches++;
      end else begin
        want = expected_descr.pop_front();
        check_field("lead_len",     want.n1,  m_data[7:0]);
        check_field("lead_bit",     want.b1,  m_data[8]);
        check_field("high_len",     want.nhi, m_data[13:9]);
        check_field("high_bits",    want.ghi, m_data[38:14]);
        check_field("mid_len",      want.n2,  m_data[45:39]);
        check_field("mid_bit",      want.b2,  m_data[46]);
        check_field("low_len",      want.nlo, m_data[51:47]);
        check_field("low_bits",     want.glo, m_data[75:52]);
        check_field("selected_bit", want.sel, m_data[76]);
        check_field("error",        want.err, m_user);
      end
    end
  end

  // Watchdog: count cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("exact_float_difference_bits_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_cases();
    test_random_queries(160, 0, 0);
    test_random_queries(160, 75, 0);
    test_random_queries(160, 0, 75);
    test_random_queries(160, 10, 10);
    test_output_hold();
    s_valid = 1'b0;
    recv_stall_pct = 0;
    while (expected_descr.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("exact_float_difference_bits_unit: match");
    end else begin
      $display("exact_float_difference_bits_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/efdb_pkg.sv
hw/rtl/exact_float_difference_bits_unit.sv
hw/rtl/efdb_checker.sv
tb/testbench.sv
